### rtl/pbfd_pkg.sv
package pbfd_pkg;

  localparam int ERR_W   = 32;
  localparam int DT_W    = 24;
  localparam int GAIN_W  = 31;
  localparam int ST_W    = 48;
  localparam int PROD_W  = 64;
  localparam int SUM_W   = 50;
  localparam int DIFF_W  = 51;
  localparam int MC_W    = 59;
  localparam int STEP_W  = 4;
  localparam int FRAC_SH = 16;

  localparam int FILTER_COEFF  = 100;
  localparam int BACKCALC_GAIN = 100;

  localparam logic signed [PROD_W-1:0] ST_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [PROD_W-1:0] ST_MIN64 = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    REG_KP  = 2'd0,
    REG_KI  = 2'd1,
    REG_KD  = 2'd2,
    REG_LIM = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_ERR,
    A_DLO,
    A_DHI,
    A_RLO,
    A_RHI
  } mul_a_e;

  typedef enum logic [2:0] {
    B_NONE,
    B_KP,
    B_KI,
    B_KD,
    B_DT
  } mul_b_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_DIFF,
    OP_DTERM,
    OP_SUM,
    OP_CLAMP,
    OP_BACK,
    OP_SCALE,
    OP_RATE,
    OP_LOW,
    OP_RSUM,
    OP_INTUPD
  } op_e;

  typedef enum logic {
    J_NONE,
    J_DT_ZERO
  } jcond_e;

  typedef struct packed {
    mul_a_e             mul_a;
    mul_b_e             mul_b;
    op_e                op;
    logic               emit;
    logic               last;
    jcond_e             jcond;
    logic [STEP_W-1:0]  jtgt;
  } uword_t;

  typedef struct packed {
    mul_a_e mul_a;
    mul_b_e mul_b;
    op_e    op;
    logic   go;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic emit;
  } seq_stat_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] lim;
  } gains_t;

  function automatic uword_t mk(input mul_a_e a, input mul_b_e b, input op_e op,
                                input logic emit, input logic last);
    uword_t w;
    w.mul_a = a;
    w.mul_b = b;
    w.op    = op;
    w.emit  = emit;
    w.last  = last;
    w.jcond = J_NONE;
    w.jtgt  = '0;
    return w;
  endfunction

  // microprogram, one control word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      4'd0:    w = mk(A_ERR,  B_KD,   OP_CLEAR,  1'b0, 1'b0);
      4'd1:    w = mk(A_ERR,  B_KP,   OP_DIFF,   1'b0, 1'b0);
      4'd2:    w = mk(A_ERR,  B_KI,   OP_DTERM,  1'b0, 1'b0);
      4'd3:    w = mk(A_DLO,  B_DT,   OP_SUM,    1'b0, 1'b0);
      4'd4:    w = mk(A_DHI,  B_DT,   OP_CLAMP,  1'b1, 1'b0);
      4'd5:    w = mk(A_NONE, B_NONE, OP_BACK,   1'b0, 1'b0);
      4'd6: begin
        w = mk(A_NONE, B_NONE, OP_SCALE, 1'b0, 1'b0);
        w.jcond = J_DT_ZERO;
        w.jtgt  = 4'd12;
      end
      4'd7:    w = mk(A_NONE, B_NONE, OP_RATE,   1'b0, 1'b0);
      4'd8:    w = mk(A_RLO,  B_DT,   OP_NOP,    1'b0, 1'b0);
      4'd9:    w = mk(A_RHI,  B_DT,   OP_LOW,    1'b0, 1'b0);
      4'd10:   w = mk(A_NONE, B_NONE, OP_RSUM,   1'b0, 1'b0);
      4'd11:   w = mk(A_NONE, B_NONE, OP_INTUPD, 1'b0, 1'b1);
      default: w = mk(A_NONE, B_NONE, OP_NOP,    1'b0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    if (v > ST_MAX64) begin
      r = ST_MAX64;
    end else if (v < ST_MIN64) begin
      r = ST_MIN64;
    end else begin
      r = v;
    end
    return r[ST_W-1:0];
  endfunction

endpackage

### rtl/pbfd_sequencer.sv
module pbfd_sequencer
  import pbfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      dt_zero_i,
  input  logic      out_free_i,
  output ctrl_t     ctrl_o,
  output seq_stat_t stat_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    uw     = ucode(step_q);
    go     = busy_q && !(uw.emit && !out_free_i);
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (go) begin
      if (uw.last) begin
        busy_d = start_i;
        step_d = '0;
      end else if (uw.jcond == J_DT_ZERO && dt_zero_i) begin
        step_d = uw.jtgt;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    ctrl_o.mul_a = uw.mul_a;
    ctrl_o.mul_b = uw.mul_b;
    ctrl_o.op    = uw.op;
    ctrl_o.go    = go;
    stat_o.busy  = busy_q;
    stat_o.done  = go && uw.last;
    stat_o.emit  = go && uw.emit;
  end

endmodule

### rtl/pbfd_datapath.sv
module pbfd_datapath
  import pbfd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic signed [ERR_W-1:0] error_value_i,
  input  logic [DT_W-1:0]         time_step_i,
  input  logic                    reset_request_i,
  input  gains_t                  gains_i,
  input  ctrl_t                   ctrl_i,
  output logic                    dt_zero_o,
  output logic signed [ERR_W-1:0] drive_o
);

  localparam logic signed [MC_W-1:0] FILT_K = MC_W'(FILTER_COEFF);
  localparam logic signed [MC_W-1:0] BACK_K = MC_W'(BACKCALC_GAIN);

  // item registers
  logic signed [ERR_W-1:0]  e_q;
  logic [DT_W-1:0]          dt_q;
  logic                     rq_q;

  // persistent state
  logic signed [ST_W-1:0]   integ_q, integ_d;
  logic signed [ST_W-1:0]   filt_q, filt_d;
  logic                     seen_q, seen_d;

  // scratch
  logic signed [PROD_W-1:0] p_q, p_d;
  logic signed [DIFF_W-1:0] t1_q, t1_d;
  logic signed [ST_W-1:0]   gp_q, gp_d;
  logic signed [ST_W-1:0]   gi_q, gi_d;
  logic signed [ST_W-1:0]   dterm_q, dterm_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [ERR_W-1:0]  drv_q, drv_d;
  logic [DT_W-1:0]          lo_q, lo_d;
  logic signed [ST_W-1:0]   scl_q, scl_d;
  logic signed [MC_W-1:0]   t2_q, t2_d;
  logic signed [ST_W-1:0]   rate_q, rate_d;

  logic signed [ERR_W-1:0]  ma, mb;
  logic signed [ST_W-1:0]   gmul;
  logic signed [DIFF_W-1:0] limw, sumw;
  logic signed [ERR_W-1:0]  clamp;
  logic signed [PROD_W-1:0] scl_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      filt_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      integ_q <= integ_d;
      filt_q  <= filt_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e_q  <= error_value_i;
      dt_q <= time_step_i;
      rq_q <= reset_request_i;
    end
    p_q     <= p_d;
    t1_q    <= t1_d;
    gp_q    <= gp_d;
    gi_q    <= gi_d;
    dterm_q <= dterm_d;
    sum_q   <= sum_d;
    drv_q   <= drv_d;
    lo_q    <= lo_d;
    scl_q   <= scl_d;
    t2_q    <= t2_d;
    rate_q  <= rate_d;
  end

  // shared multiplier operands
  always_comb begin
    case (ctrl_i.mul_a)
      A_ERR:   ma = e_q;
      A_DLO:   ma = {8'b0, dterm_q[23:0]};
      A_DHI:   ma = {{8{dterm_q[ST_W-1]}}, dterm_q[ST_W-1:24]};
      A_RLO:   ma = {8'b0, rate_q[23:0]};
      A_RHI:   ma = {{8{rate_q[ST_W-1]}}, rate_q[ST_W-1:24]};
      default: ma = '0;
    endcase
    case (ctrl_i.mul_b)
      B_KP:    mb = {1'b0, gains_i.kp};
      B_KI:    mb = {1'b0, gains_i.ki};
      B_KD:    mb = {1'b0, gains_i.kd};
      B_DT:    mb = {8'b0, dt_q};
      default: mb = '0;
    endcase
  end

  // clamp against the symmetric limit
  always_comb begin
    limw = DIFF_W'(signed'({1'b0, gains_i.lim}));
    sumw = DIFF_W'(sum_q);
    if (sumw > limw) begin
      clamp = ERR_W'(limw);
    end else if (sumw < -limw) begin
      clamp = ERR_W'(-limw);
    end else begin
      clamp = ERR_W'(sumw);
    end
  end

  assign gmul      = p_q[PROD_W-1:FRAC_SH];
  assign scl_sum   = p_q + PROD_W'(signed'({1'b0, lo_q}));
  assign dt_zero_o = (dt_q == '0);
  assign drive_o   = clamp;

  always_comb begin
    integ_d = integ_q;
    filt_d  = filt_q;
    seen_d  = seen_q;
    p_d     = p_q;
    t1_d    = t1_q;
    gp_d    = gp_q;
    gi_d    = gi_q;
    dterm_d = dterm_q;
    sum_d   = sum_q;
    drv_d   = drv_q;
    lo_d    = lo_q;
    scl_d   = scl_q;
    t2_d    = t2_q;
    rate_d  = rate_q;
    if (ctrl_i.go) begin
      p_d = ma * mb;
      case (ctrl_i.op)
        OP_CLEAR: begin
          if (rq_q || seen_q) begin
            integ_d = '0;
            filt_d  = '0;
          end
          seen_d = rq_q;
        end
        OP_DIFF: begin
          t1_d = DIFF_W'(gmul) - DIFF_W'(filt_q);
        end
        OP_DTERM: begin
          gp_d    = gmul;
          dterm_d = sat_st(PROD_W'(MC_W'(t1_q) * FILT_K));
        end
        OP_SUM: begin
          gi_d  = gmul;
          sum_d = SUM_W'(gp_q) + SUM_W'(integ_q) + SUM_W'(dterm_q);
        end
        OP_CLAMP: begin
          drv_d = clamp;
          lo_d  = p_q[ST_W-1:DT_W];
        end
        OP_BACK: begin
          t1_d  = DIFF_W'(drv_q) - DIFF_W'(sum_q);
          scl_d = scl_sum[ST_W-1:0];
        end
        OP_SCALE: begin
          t2_d   = MC_W'(t1_q) * BACK_K;
          filt_d = sat_st(PROD_W'(filt_q) + PROD_W'(scl_q));
        end
        OP_RATE: begin
          rate_d = sat_st(PROD_W'(gi_q) + PROD_W'(t2_q));
        end
        OP_LOW: begin
          lo_d = p_q[ST_W-1:DT_W];
        end
        OP_RSUM: begin
          scl_d = scl_sum[ST_W-1:0];
        end
        OP_INTUPD: begin
          integ_d = sat_st(PROD_W'(integ_q) + PROD_W'(scl_q));
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/pid_backcalc_filtered_derivative.sv
// channel   ports                                          transfer when
// input     in_valid_i, in_stall_o, error_value_i,         in_valid_i & !in_stall_o
//           time_step_i, reset_request_i
// output    out_valid_o, out_stall_i, drive_o              out_valid_o & !out_stall_i
// config    cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i
//
// one item runs 12 microcode steps, 8 when time_step is zero; every step drives
// the single shared 32x32 multiplier and its registered product
// the next item is taken during the last step of the current one
// the drive is emitted at step 4, which waits while the output register is full and stalled
// reset clears the gains, the integrator, the filter state and the last reset flag
module pid_backcalc_filtered_derivative
  import pbfd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [GAIN_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ERR_W-1:0] error_value_i,
  input  logic [DT_W-1:0]         time_step_i,
  input  logic                    reset_request_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ERR_W-1:0] drive_o
);

  gains_t                  gains_q, gains_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [ERR_W-1:0] drive_q, drive_d;
  ctrl_t                   ctrl;
  seq_stat_t               stat;
  logic                    start, dt_zero, out_free;
  logic signed [ERR_W-1:0] dp_drive;

  assign in_stall_o  = stat.busy && !stat.done;
  assign start       = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  pbfd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dt_zero_i  (dt_zero),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .stat_o     (stat)
  );

  pbfd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (start),
    .error_value_i   (error_value_i),
    .time_step_i     (time_step_i),
    .reset_request_i (reset_request_i),
    .gains_i         (gains_q),
    .ctrl_i          (ctrl),
    .dt_zero_o       (dt_zero),
    .drive_o         (dp_drive)
  );

  always_comb begin
    gains_d = gains_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_KP:  gains_d.kp  = cfg_data_i;
        REG_KI:  gains_d.ki  = cfg_data_i;
        REG_KD:  gains_d.kd  = cfg_data_i;
        REG_LIM: gains_d.lim = cfg_data_i;
        default: gains_d = gains_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    if (stat.emit) begin
      out_valid_d = 1'b1;
      drive_d     = dp_drive;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gains_q     <= gains_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
  end

endmodule

### test/pid_backcalc_filtered_derivative_tb.sv
`timescale 1ns / 100ps

module pid_backcalc_filtered_derivative_tb;
  import pbfd_pkg::*;

  localparam int HOLD_LEN  = 300;
  localparam int TAIL_CYC  = 20;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 192;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [DT_W-1:0]         dt;
    logic                    rq;
  } pid_sample_t;

  logic                    clk;
  logic                    rst_n    = 1'b0;
  logic                    cfg_we   = 1'b0;
  logic [1:0]              cfg_idx  = '0;
  logic [GAIN_W-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [ERR_W-1:0] err_in   = '0;
  logic [DT_W-1:0]         dt_in    = '0;
  logic                    rq_in    = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ERR_W-1:0] drive;

  pid_backcalc_filtered_derivative i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .error_value_i  (err_in),
    .time_step_i    (dt_in),
    .reset_request_i(rq_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .drive_o        (drive)
  );

  // gain shadows and controller state
  logic [GAIN_W-1:0] kp_cfg  = '0;
  logic [GAIN_W-1:0] ki_cfg  = '0;
  logic [GAIN_W-1:0] kd_cfg  = '0;
  logic [GAIN_W-1:0] lim_cfg = '0;
  longint            integ_acc = 0;
  longint            filt_acc  = 0;
  logic              rq_last   = 1'b0;

  pid_sample_t             pending_q[$];
  logic signed [ERR_W-1:0] drive_q[$];
  pid_sample_t             drv_item;
  logic signed [ERR_W-1:0] drive_exp;

  logic        steady   = 1'b0;
  logic        hold_req = 1'b0;
  logic [15:0] hold_cnt = '0;

  int fail_cnt   = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_clamped  = 0;
  int n_clears   = 0;
  int n_settings = 0;

  function automatic longint clip48(longint v);
    if (v > ST_MAX64) return ST_MAX64;
    if (v < ST_MIN64) return ST_MIN64;
    return v;
  endfunction

  function automatic longint gain_scale(longint e, logic [GAIN_W-1:0] g);
    return (e * longint'(g)) >>> FRAC_SH;
  endfunction

  function automatic longint dt_scale(longint r, logic [DT_W-1:0] dt);
    longint part_hi;
    longint part_lo;
    part_hi = r * longint'(dt[23:12]);
    part_lo = r * longint'(dt[11:0]);
    return (part_hi + (part_lo >>> 12)) >>> 12;
  endfunction

  function automatic logic signed [ERR_W-1:0] pid_step(logic signed [ERR_W-1:0] err,
                                                       logic [DT_W-1:0] dt, logic rq);
    longint e;
    longint lim;
    longint dterm;
    longint total;
    longint out;
    longint rate;
    e   = err;
    lim = longint'(lim_cfg);
    if (rq || rq_last) begin
      integ_acc = 0;
      filt_acc  = 0;
      n_clears++;
    end
    dterm = clip48((gain_scale(e, kd_cfg) - filt_acc) * FILTER_COEFF);
    total = gain_scale(e, kp_cfg) + integ_acc + dterm;
    if (total > lim) begin
      out = lim;
    end else if (total < -lim) begin
      out = -lim;
    end else begin
      out = total;
    end
    if (out != total) n_clamped++;
    rate      = clip48(gain_scale(e, ki_cfg) + BACKCALC_GAIN * (out - total));
    integ_acc = clip48(integ_acc + dt_scale(rate, dt));
    filt_acc  = clip48(filt_acc + dt_scale(dterm, dt));
    rq_last   = rq;
    return out[ERR_W-1:0];
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error();
    logic [31:0] m;
    m = $urandom() >> $urandom_range(31, 10);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(2))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          default: return '0;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return $urandom_range(1) ? -m : m;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return DT_W'($urandom());
      default: return DT_W'($urandom_range(33554, 1));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    return GAIN_W'($urandom() >> $urandom_range(31, 1));
  endfunction

  task automatic push_sample(logic signed [ERR_W-1:0] err, logic [DT_W-1:0] dt, logic rq);
    pid_sample_t s;
    s.err = err;
    s.dt  = dt;
    s.rq  = rq;
    pending_q.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || drive_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_KP:  kp_cfg  = val;
      REG_KI:  ki_cfg  = val;
      REG_KD:  kd_cfg  = val;
      REG_LIM: lim_cfg = val;
      default: ;
    endcase
  endtask

  task automatic load_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                            logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] lim);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_LIM, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
        drv_item = pending_q.pop_front();
        in_valid <= 1'b1;
        err_in   <= drv_item.err;
        dt_in    <= drv_item.dt;
        rq_in    <= drv_item.rq;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt != HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (drive_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected drive %0d with nothing outstanding", drive);
      end else begin
        drive_exp = drive_q.pop_front();
        if (drive_exp !== drive) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("drive mismatch: expected %0d (%h) got %0d (%h)",
                     drive_exp, drive_exp, drive, drive);
          end
        end
      end
    end
    // input transfer: predict its drive
    if (rst_n && in_valid && !in_stall) begin
      drive_q.push_back(pid_step(err_in, dt_in, rq_in));
      n_items++;
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // gains and limit still at reset: zero limit
    push_sample(32'sh7FFF_FFFF, '1, 1'b0);
    push_sample(32'sh8000_0000, '1, 1'b0);
    push_sample('0, '0, 1'b1);
    push_sample(32'sh0000_0001, 24'h000001, 1'b0);
    push_sample(-32'sd1, '0, 1'b0);
    wait_idle();

    // everything at full scale: saturation, clear and zero step cases
    load_gains('1, '1, '1, '1);
    push_sample(32'sh7FFF_FFFF, '1, 1'b0);
    push_sample(32'sh8000_0000, '1, 1'b0);
    push_sample(32'sh7FFF_FFFF, '1, 1'b0);
    push_sample(32'sh7FFF_FFFF, '1, 1'b0);
    push_sample('0, '0, 1'b0);
    push_sample('0, '1, 1'b1);
    push_sample(32'sh7FFF_FFFF, '1, 1'b0);
    push_sample(-32'sd1, 24'h000001, 1'b0);
    push_sample(32'sh0000_0001, 24'h800000, 1'b1);
    push_sample(32'sh0000_0001, 24'h800000, 1'b1);
    push_sample(32'sh8000_0000, '0, 1'b0);
    push_sample(32'sh0001_0000, 24'h001000, 1'b0);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: load_gains(31'h0002_0000, 31'h0000_8000, 31'h0000_0CCD, 31'h0032_0000);
        1: load_gains('1, '1, '1, '1);
        2: load_gains('1, '0, '1, 31'h0100_0000);
        3: load_gains(31'h0001_0000, 31'h0001_0000, 31'h0000_0100, '1);
        default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      endcase
      steady = (phase == 3);
      if (phase == 5) hold_req = 1'b1;
      repeat (PHASE_LEN) push_sample(pick_error(), pick_dt(), $urandom_range(99) < 4);
    end
    wait_idle();

    $display("%0d samples over %0d gain settings, %0d drives checked", n_items, n_settings,
             n_results);
    $display("%0d drives at the clamp, %0d state clears", n_clamped, n_clears);
    if (fail_cnt == 0 && drive_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d drives still outstanding", fail_cnt, drive_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
